FILE: design/rpc_pkg.sv
package rpc_pkg;

	localparam int MAX_REGIONS = 64;
	localparam int ADDR_BITS = 48;
	localparam int FIELD_W = 48;
	localparam int PERM_W = 3;
	localparam int IDX_W = $clog2(MAX_REGIONS);
	localparam int CNT_W = $clog2(MAX_REGIONS + 1);
	localparam int SUM_W = ((FIELD_W > ADDR_BITS) ? FIELD_W : ADDR_BITS) + 1;

	localparam logic [PERM_W-1:0] PERM_RD = 3'b001;
	localparam logic [PERM_W-1:0] PERM_WR = 3'b010;
	localparam logic [PERM_W-1:0] PERM_EX = 3'b100;
	localparam logic [PERM_W-1:0] PERM_MASK = PERM_RD | PERM_WR | PERM_EX;

	localparam logic [ADDR_BITS-1:0] ADDR_MASK = {ADDR_BITS{1'b1}};

	typedef logic [ADDR_BITS-1:0] addr_t;
	typedef logic [PERM_W-1:0] perm_t;

	typedef enum logic [1:0] {
		REQ_CLEAR  = 2'd0,
		REQ_APPEND = 2'd1,
		REQ_CHECK  = 2'd2,
		REQ_LOOKUP = 2'd3
	} req_kind_t;

	typedef struct packed {
		perm_t perms;
		addr_t limit;
		addr_t start;
	} entry_t;

	typedef struct packed {
		req_kind_t          kind;
		addr_t              address;
		addr_t              region_limit;
		perm_t              region_perms;
		logic [FIELD_W-1:0] span_length;
		perm_t              need_perms;
	} req_t;

	typedef struct packed {
		logic  valid;
		logic  permitted;
		logic  found;
		perm_t found_perms;
		logic  table_full;
	} res_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		entry_t           data;
	} mem_wr_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
	} mem_rd_t;

endpackage

FILE: design/rpc_table.sv
module rpc_table (
	input  logic             clk,
	input  rpc_pkg::mem_wr_t wr,
	input  rpc_pkg::mem_rd_t rd,
	output rpc_pkg::entry_t  rd_data_q
);
	import rpc_pkg::*;

	entry_t mem_q [MAX_REGIONS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rd_data_q <= mem_q[rd.addr];
		end
	end

endmodule

FILE: design/rpc_walker.sv
module rpc_walker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  rpc_pkg::req_t    req,
	output rpc_pkg::res_t    res,
	input  logic             res_ready,
	output rpc_pkg::mem_wr_t mem_wr,
	output rpc_pkg::mem_rd_t mem_rd,
	input  rpc_pkg::entry_t  rd_data
);
	import rpc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WALK = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] idx_q, idx_d;
	logic             is_check_q, is_check_d;
	addr_t            addr_q, addr_d;
	addr_t            end_q, end_d;
	addr_t            cursor_q, cursor_d;
	perm_t            need_q, need_d;
	logic             permitted_q, permitted_d;
	logic             found_q, found_d;
	perm_t            found_perms_q, found_perms_d;
	logic             full_q, full_d;

	logic             accept;
	perm_t            need_in;
	perm_t            entry_perms;
	logic [SUM_W-1:0] span_sum;
	logic             span_bad;
	logic [CNT_W-1:0] idx_next;
	logic             last_entry;

	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;
	assign need_in = req.need_perms & PERM_MASK;
	assign entry_perms = rd_data.perms & PERM_MASK;
	assign span_sum = SUM_W'(req.span_length) + SUM_W'(req.address);
	assign span_bad = (req.span_length == '0) || (req.address == '0)
		|| (span_sum > SUM_W'(ADDR_MASK));
	assign idx_next = idx_q + CNT_W'(1);
	assign last_entry = (idx_next == count_q);

	assign res.valid = (state_q == ST_FIN);
	assign res.permitted = permitted_q;
	assign res.found = found_q;
	assign res.found_perms = found_perms_q;
	assign res.table_full = full_q;

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		idx_d = idx_q;
		is_check_d = is_check_q;
		addr_d = addr_q;
		end_d = end_q;
		cursor_d = cursor_q;
		need_d = need_q;
		permitted_d = permitted_q;
		found_d = found_q;
		found_perms_d = found_perms_q;
		full_d = full_q;
		mem_wr.en = 1'b0;
		mem_wr.addr = count_q[IDX_W-1:0];
		mem_wr.data.start = req.address;
		mem_wr.data.limit = req.region_limit;
		mem_wr.data.perms = req.region_perms & PERM_MASK;
		mem_rd.en = 1'b0;
		mem_rd.addr = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					permitted_d = 1'b0;
					found_d = 1'b0;
					found_perms_d = '0;
					full_d = 1'b0;
					idx_d = '0;
					is_check_d = (req.kind == REQ_CHECK);
					addr_d = req.address;
					end_d = span_sum[ADDR_BITS-1:0];
					cursor_d = req.address;
					need_d = need_in;
					state_d = ST_FIN;
					unique case (req.kind)
						REQ_CLEAR: begin
							count_d = '0;
						end
						REQ_APPEND: begin
							if (req.region_limit > req.address) begin
								if (count_q == CNT_W'(MAX_REGIONS)) begin
									full_d = 1'b1;
								end else begin
									mem_wr.en = 1'b1;
									count_d = count_q + CNT_W'(1);
								end
							end
						end
						REQ_CHECK: begin
							if (!span_bad && count_q != '0) begin
								mem_rd.en = 1'b1;
								state_d = ST_WALK;
							end
						end
						REQ_LOOKUP: begin
							if (count_q != '0) begin
								mem_rd.en = 1'b1;
								state_d = ST_WALK;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_WALK: begin
				mem_rd.en = 1'b1;
				mem_rd.addr = idx_next[IDX_W-1:0];
				idx_d = idx_next;
				if (is_check_q) begin
					priority if (rd_data.limit <= cursor_q) begin
						if (last_entry) begin
							state_d = ST_FIN;
						end
					end else if (rd_data.start > cursor_q
						|| (entry_perms & need_q) != need_q) begin
						state_d = ST_FIN;
					end else if (rd_data.limit >= end_q) begin
						permitted_d = 1'b1;
						state_d = ST_FIN;
					end else begin
						cursor_d = rd_data.limit;
						if (last_entry) begin
							state_d = ST_FIN;
						end
					end
				end else begin
					priority if (addr_q >= rd_data.start && addr_q < rd_data.limit) begin
						found_d = 1'b1;
						found_perms_d = entry_perms;
						state_d = ST_FIN;
					end else if (rd_data.start > addr_q || last_entry) begin
						state_d = ST_FIN;
					end else begin
					end
				end
			end
			ST_FIN: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		is_check_q <= is_check_d;
		addr_q <= addr_d;
		end_q <= end_d;
		cursor_q <= cursor_d;
		need_q <= need_d;
		permitted_q <= permitted_d;
		found_q <= found_d;
		found_perms_q <= found_perms_d;
		full_q <= full_d;
	end

endmodule

FILE: design/region_permission_checker_top.sv
// Keeps an ordered table of up to 64 address regions and answers one result word per
// request word: clear, append, span check or single-address lookup. The table lives in
// a single synchronous memory with one read port, so a check or lookup walks it one
// entry per cycle, visiting at most 64 entries before the answer is known. A clear, an
// append, or a check that fails its length, address or overflow test goes straight to
// its result without a walk. One request is in work at a time; the finished result
// sits in an output register, so a new request can be taken while the previous result
// waits on m_tready.
module region_permission_checker_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// address[47:0], region_limit[95:48], region_perms[98:96], span_length[146:99],
	// need_perms[149:147], zero padding[151:150].
	input  logic [151:0] s_tdata,
	// req_type[1:0].
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// permitted[0], found[1], found_perms[4:2], table_full[5], zero padding[7:6].
	output logic [7:0]   m_tdata
);
	import rpc_pkg::*;

	req_t    req;
	res_t    res;
	logic    res_ready;
	mem_wr_t mem_wr;
	mem_rd_t mem_rd;
	entry_t  rd_data;

	logic       out_valid_q;
	logic [5:0] out_data_q;

	assign req.kind = req_kind_t'(s_tuser);
	assign req.address = addr_t'(s_tdata[47:0]);
	assign req.region_limit = addr_t'(s_tdata[95:48]);
	assign req.region_perms = s_tdata[98:96];
	assign req.span_length = s_tdata[146:99];
	assign req.need_perms = s_tdata[149:147];

	rpc_walker u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.req       (req),
		.res       (res),
		.res_ready (res_ready),
		.mem_wr    (mem_wr),
		.mem_rd    (mem_rd),
		.rd_data   (rd_data)
	);

	rpc_table u_table (
		.clk       (clk),
		.wr        (mem_wr),
		.rd        (mem_rd),
		.rd_data_q (rd_data)
	);

	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid && res_ready) begin
			out_data_q <= {res.table_full, res.found_perms, res.found, res.permitted};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {2'b00, out_data_q};

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("walker still ready after taking a request");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res_ready |=> m_tvalid)
		else $error("finished result not presented on the output");

	a_one_answer: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $countones({m_tdata[0], m_tdata[1], m_tdata[5]}) <= 1)
		else $error("result word carries answers of more than one request type");

	a_perms_need_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[1] |-> m_tdata[4:2] == 3'b000)
		else $error("permission bits reported without a matching region");

endmodule
